### sv/mlsc_pkg.sv
package mlsc_pkg;

   localparam int LINES_DEFAULT = 1024;
   localparam int LOCK_BITS_DEFAULT = 4;
   localparam int INDEX_W = 10;
   localparam int CMD_W = 4;

   typedef enum logic [3:0] {
      CMD_EVICT      = 4'd0,
      CMD_GETS       = 4'd1,
      CMD_GETX       = 4'd2,
      CMD_GETSEX     = 4'd3,
      CMD_PUTS       = 4'd4,
      CMD_PUTM       = 4'd5,
      CMD_PUTX       = 4'd6,
      CMD_PUTXE      = 4'd7,
      CMD_PUTE       = 4'd8,
      CMD_INV        = 4'd9,
      CMD_FETCHINV   = 4'd10,
      CMD_FETCHINVX  = 4'd11,
      CMD_FILL       = 4'd12,
      CMD_FETCH_RESP = 4'd13,
      CMD_BAD        = 4'd14
   } cmd_type;

   typedef enum logic [2:0] {
      ST_I  = 3'd0,
      ST_S  = 3'd1,
      ST_E  = 3'd2,
      ST_M  = 3'd3,
      ST_IS = 3'd4,
      ST_IM = 3'd5,
      ST_SM = 3'd6
   } state_type;

   typedef enum logic [2:0] {
      MSG_NONE = 3'd0,
      MSG_FWD  = 3'd1,
      MSG_PUTS = 3'd2,
      MSG_PUTE = 3'd3,
      MSG_PUTM = 3'd4,
      MSG_DATA = 3'd5
   } msg_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_ILLEGAL = 2'd1,
      ERR_NODATA  = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [INDEX_W-1:0]   line_index;
      logic                 in_range;
      logic                 ack_needed;
      logic                 dirty_in;
      logic                 granted_exclusive;
      logic                 load_link;
      logic                 store_conditional;
      logic                 locked_access;
      logic                 orig_is_data_request;
   } item_type;

   typedef struct packed {
      msg_type    message;
      logic       message_dirty;
      logic       write_data;
      err_type    error_code;
      state_type  new_state;
   } rsp_type;

endpackage

### sv/mlsc_queue.sv
module mlsc_queue
   import mlsc_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH);
   assign empty   = (count_ff == 2'd0);
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### sv/mlsc_front.sv
module mlsc_front
   import mlsc_pkg::*;
#(
   parameter int LINES = LINES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               hold,
   input  logic               req_push,
   output logic               req_full,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [INDEX_W-1:0] req_line_index,
   input  logic               req_ack_needed,
   input  logic               req_dirty_in,
   input  logic               req_granted_exclusive,
   input  logic               req_load_link,
   input  logic               req_store_conditional,
   input  logic               req_locked_access,
   input  logic               req_orig_is_data_request,
   input  logic               head_pop,
   output item_type           head,
   output logic               head_empty
);

   localparam int ITEM_W = $bits(item_type);

   item_type          item;
   logic              q_full;
   logic [ITEM_W-1:0] q_dout;
   cmd_type           cmd_raw;

   assign cmd_raw = cmd_type'(req_cmd);

   always_comb begin
      item = '0;
      if (cmd_raw inside {[CMD_EVICT:CMD_FETCH_RESP]}) begin
         item.cmd = cmd_raw;
      end else begin
         item.cmd = CMD_BAD;
      end
      item.line_index           = req_line_index;
      item.in_range             = (32'(req_line_index) < 32'(LINES));
      item.ack_needed           = req_ack_needed;
      item.dirty_in             = req_dirty_in;
      item.granted_exclusive    = req_granted_exclusive;
      item.load_link            = req_load_link;
      item.store_conditional    = req_store_conditional;
      item.locked_access        = req_locked_access;
      item.orig_is_data_request = req_orig_is_data_request;
   end

   assign req_full = q_full || hold;
   assign head     = item_type'(q_dout);

   mlsc_queue #(.WIDTH(ITEM_W)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push && !req_full),
      .din   (item),
      .full  (q_full),
      .pop   (head_pop),
      .dout  (q_dout),
      .empty (head_empty)
   );

endmodule

### sv/mlsc_back.sv
module mlsc_back
   import mlsc_pkg::*;
#(
   parameter int LINES     = LINES_DEFAULT,
   parameter int LOCK_BITS = LOCK_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     is_first_level,
   output logic     clearing,
   input  item_type head,
   input  logic     head_empty,
   output logic     head_pop,
   input  logic     rsp_pop,
   output rsp_type  rsp,
   output logic     rsp_empty
);

   localparam int AW     = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int WORD_W = 4 + LOCK_BITS;
   localparam int RSP_W  = $bits(rsp_type);
   localparam logic [LOCK_BITS-1:0] LOCK_MAX = '1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(LINES - 1);

   logic [WORD_W-1:0] mem [LINES];

   back_state_type    bk_state_ff, bk_state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   item_type          item_ff, item_in;
   logic [WORD_W-1:0] rd_ff;

   logic              rd_en, mem_we;
   logic [AW-1:0]     rd_addr, wr_addr, item_addr;
   logic [WORD_W-1:0] wr_word;
   logic [31:0]       head_wide, item_wide;
   logic              rsp_full, rsp_push;
   logic [RSP_W-1:0]  rsp_dout;

   state_type            s, ns;
   logic                 mark, nmark;
   logic [LOCK_BITS-1:0] lock, nlock;
   msg_type              msg;
   logic                 mdirty, wr;
   err_type              err;
   rsp_type              res;
   logic                 l1;

   assign head_wide = 32'(head.line_index);
   assign item_wide = 32'(item_ff.line_index);
   assign rd_addr   = head_wide[AW-1:0];
   assign item_addr = item_wide[AW-1:0];
   assign clearing  = (bk_state_ff == BK_CLEAR);
   assign l1        = is_first_level;

   assign s    = state_type'(rd_ff[2:0]);
   assign mark = rd_ff[3];
   assign lock = rd_ff[WORD_W-1:4];

   always_comb begin
      ns     = s;
      nmark  = mark;
      nlock  = lock;
      msg    = MSG_NONE;
      mdirty = 1'b0;
      wr     = 1'b0;
      err    = ERR_OK;
      case (item_ff.cmd)
         CMD_EVICT: begin
            if (s == ST_S) begin
               msg = MSG_PUTS;
               ns  = ST_I;
            end else if (s == ST_E) begin
               msg = MSG_PUTE;
               ns  = ST_I;
            end else if (s == ST_M) begin
               msg    = MSG_PUTM;
               mdirty = 1'b1;
               ns     = ST_I;
            end else begin
               err = ERR_ILLEGAL;
            end
         end
         CMD_GETS: begin
            if (item_ff.load_link) begin
               nmark = 1'b1;
            end
            if (s == ST_I) begin
               ns  = ST_IS;
               msg = MSG_FWD;
            end
         end
         CMD_GETX, CMD_GETSEX: begin
            if (s == ST_S) begin
               ns  = ST_SM;
               msg = MSG_FWD;
            end else if (s == ST_I) begin
               ns  = ST_IM;
               msg = MSG_FWD;
            end else begin
               if (s == ST_E) begin
                  ns = ST_M;
               end
               if (item_ff.cmd == CMD_GETX) begin
                  if (l1 && item_ff.locked_access) begin
                     if (lock == '0) begin
                        err = ERR_ILLEGAL;
                     end else begin
                        nlock = lock - 1'b1;
                     end
                  end
                  if (l1 && (!item_ff.store_conditional || mark)) begin
                     wr = 1'b1;
                  end
               end else if (l1 && (lock != LOCK_MAX)) begin
                  nlock = lock + 1'b1;
               end
            end
         end
         CMD_PUTS: begin
         end
         CMD_PUTM, CMD_PUTX, CMD_PUTXE: begin
            if (s != ST_M && s != ST_E) begin
               err = ERR_ILLEGAL;
            end else begin
               if ((s == ST_E && item_ff.cmd != CMD_PUTXE) || item_ff.dirty_in) begin
                  ns = ST_M;
               end
               wr = (item_ff.cmd != CMD_PUTXE);
            end
         end
         CMD_PUTE: begin
            if (s != ST_M && s != ST_E) begin
               err = ERR_ILLEGAL;
            end
         end
         CMD_INV: begin
            if (s inside {ST_IS, ST_IM, ST_SM}) begin
               nmark = 1'b0;
               if (item_ff.ack_needed && s == ST_SM) begin
                  ns  = ST_IM;
                  msg = MSG_PUTS;
               end
            end else if (s == ST_S) begin
               nmark = 1'b0;
               if (item_ff.ack_needed) begin
                  msg = MSG_PUTS;
               end
               ns = ST_I;
            end else begin
               err = ERR_ILLEGAL;
            end
         end
         CMD_FETCHINV, CMD_FETCHINVX: begin
            if (s != ST_M && s != ST_E) begin
               err = ERR_ILLEGAL;
            end else begin
               nmark  = 1'b0;
               msg    = MSG_DATA;
               mdirty = (s == ST_M);
               ns     = (item_ff.cmd == CMD_FETCHINV) ? ST_I : ST_S;
            end
         end
         CMD_FILL: begin
            if (!item_ff.orig_is_data_request) begin
               err = ERR_NODATA;
            end else begin
               if (s == ST_S || s == ST_IS) begin
                  ns = item_ff.granted_exclusive ? ST_E : ST_S;
               end else if (s inside {ST_M, ST_IM, ST_SM}) begin
                  ns = ST_M;
               end
               wr = 1'b1;
            end
         end
         CMD_FETCH_RESP: begin
            wr = 1'b1;
            if (item_ff.dirty_in) begin
               ns = ST_M;
            end
         end
         default: begin
            err = ERR_ILLEGAL;
         end
      endcase

      res.message       = msg;
      res.message_dirty = mdirty;
      res.write_data    = wr;
      res.error_code    = err;
      res.new_state     = ns;
      if (!item_ff.in_range) begin
         res = '0;
         res.error_code = ERR_ILLEGAL;
         res.new_state  = ST_I;
      end else if (err != ERR_OK) begin
         res = '0;
         res.error_code = err;
         res.new_state  = s;
      end
   end

   always_comb begin
      bk_state_in = bk_state_ff;
      clr_addr_in = clr_addr_ff;
      item_in     = item_ff;
      head_pop    = 1'b0;
      rd_en       = 1'b0;
      rsp_push    = 1'b0;
      mem_we      = 1'b0;
      wr_addr     = item_addr;
      wr_word     = {nlock, nmark, ns};
      case (bk_state_ff)
         BK_CLEAR: begin
            mem_we      = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_word     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               bk_state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!head_empty) begin
               head_pop    = 1'b1;
               rd_en       = 1'b1;
               item_in     = head;
               bk_state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (!rsp_full) begin
               rsp_push    = 1'b1;
               mem_we      = item_ff.in_range && (err == ERR_OK);
               bk_state_in = BK_IDLE;
            end
         end
         default: begin
            bk_state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bk_state_ff <= BK_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         bk_state_ff <= bk_state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_word;
      end
   end

   assign rsp = rsp_type'(rsp_dout);

   mlsc_queue #(.WIDTH(RSP_W)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (res),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp_dout),
      .empty (rsp_empty)
   );

endmodule

### sv/mesi_line_state_controller.sv
// A word accepted on req_ goes through the command queue, then an event register that
// holds it with its line state read, then the result queue to the rsp_ ports. Words go
// one at a time: the next is taken only after the last has its line state written.
// Reset: synchronous, active high; then a clearing pass sweeps the
// line state memory one entry a cycle, with req_full high. csr_ writes are taken.
module mesi_line_state_controller
   import mlsc_pkg::*;
#(
   parameter int LINES     = LINES_DEFAULT,
   parameter int LOCK_BITS = LOCK_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               req_push,
   output logic               req_full,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [INDEX_W-1:0] req_line_index,
   input  logic               req_ack_needed,
   input  logic               req_dirty_in,
   input  logic               req_granted_exclusive,
   input  logic               req_load_link,
   input  logic               req_store_conditional,
   input  logic               req_locked_access,
   input  logic               req_orig_is_data_request,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [2:0]         rsp_message,
   output logic               rsp_message_dirty,
   output logic               rsp_write_data,
   output logic [1:0]         rsp_error_code,
   output logic [2:0]         rsp_new_state
);

   logic     is_first_level_ff;
   logic     clearing;
   item_type head;
   logic     head_empty, head_pop;
   rsp_type  rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_first_level_ff <= 1'b1;
      end else if (csr_write_enable) begin
         is_first_level_ff <= csr_write_data;
      end
   end

   mlsc_front #(.LINES(LINES)) u_front (
      .clock                    (clock),
      .reset                    (reset),
      .hold                     (clearing),
      .req_push                 (req_push),
      .req_full                 (req_full),
      .req_cmd                  (req_cmd),
      .req_line_index           (req_line_index),
      .req_ack_needed           (req_ack_needed),
      .req_dirty_in             (req_dirty_in),
      .req_granted_exclusive    (req_granted_exclusive),
      .req_load_link            (req_load_link),
      .req_store_conditional    (req_store_conditional),
      .req_locked_access        (req_locked_access),
      .req_orig_is_data_request (req_orig_is_data_request),
      .head_pop                 (head_pop),
      .head                     (head),
      .head_empty               (head_empty)
   );

   mlsc_back #(.LINES(LINES), .LOCK_BITS(LOCK_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .is_first_level (is_first_level_ff),
      .clearing       (clearing),
      .head           (head),
      .head_empty     (head_empty),
      .head_pop       (head_pop),
      .rsp_pop        (rsp_pop),
      .rsp            (rsp),
      .rsp_empty      (rsp_empty)
   );

   assign rsp_message       = rsp.message;
   assign rsp_message_dirty = rsp.message_dirty;
   assign rsp_write_data    = rsp.write_data;
   assign rsp_error_code    = rsp.error_code;
   assign rsp_new_state     = rsp.new_state;

endmodule

### sv/mlsc_checker.sv
module mlsc_checker
   import mlsc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_pop,
   input logic       rsp_empty,
   input logic [2:0] rsp_message,
   input logic       rsp_message_dirty,
   input logic       rsp_write_data,
   input logic [1:0] rsp_error_code,
   input logic [2:0] rsp_new_state
);

   a_reset_state: assert property (@(posedge clock)
      reset |=> rsp_empty && req_full)
      else $error("queues not empty or clearing pass not running after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_message)
         && $stable(rsp_error_code) && $stable(rsp_new_state))
      else $error("waiting result word changed before pop");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error_code != ERR_OK |->
         rsp_message == MSG_NONE && !rsp_message_dirty && !rsp_write_data)
      else $error("result with error carries a message or data write");

   a_dirty_msg: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_message_dirty |->
         rsp_message == MSG_PUTM || rsp_message == MSG_DATA)
      else $error("dirty flag on a message that cannot carry modified data");

endmodule

bind mesi_line_state_controller mlsc_checker u_mlsc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_pop           (rsp_pop),
   .rsp_empty         (rsp_empty),
   .rsp_message       (rsp_message),
   .rsp_message_dirty (rsp_message_dirty),
   .rsp_write_data    (rsp_write_data),
   .rsp_error_code    (rsp_error_code),
   .rsp_new_state     (rsp_new_state)
);

### tb/sv/mesi_line_state_controller_checker.sv
module mesi_line_state_controller_checker
   import mlsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [INDEX_W-1:0] req_line_index,
   input  logic               req_ack_needed,
   input  logic               req_dirty_in,
   input  logic               req_granted_exclusive,
   input  logic               req_load_link,
   input  logic               req_store_conditional,
   input  logic               req_locked_access,
   input  logic               req_orig_is_data_request,
   input  logic               rsp_pop,
   input  logic               rsp_empty,
   input  logic [2:0]         rsp_message,
   input  logic               rsp_message_dirty,
   input  logic               rsp_write_data,
   input  logic [1:0]         rsp_error_code,
   input  logic [2:0]         rsp_new_state,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int NUM_LINES = LINES_DEFAULT;
   localparam int LOCK_W = LOCK_BITS_DEFAULT;

   state_type         line_st   [NUM_LINES];
   logic              line_mark [NUM_LINES];
   logic [LOCK_W-1:0] line_lock [NUM_LINES];
   logic              first_level;
   rsp_type           pending_rsp [$];

   function automatic rsp_type apply_coherence_event(
      input logic [CMD_W-1:0]   cmd,
      input logic [INDEX_W-1:0] idx,
      input logic               ack,
      input logic               dirty,
      input logic               gr_e,
      input logic               ll,
      input logic               sc,
      input logic               locked,
      input logic               data_rq
   );
      state_type         s;
      state_type         ns;
      logic              mark;
      logic [LOCK_W-1:0] lock;
      msg_type           msg;
      logic              mdirty;
      logic              wr;
      err_type           err;
      rsp_type           r;
      msg = MSG_NONE;
      mdirty = 1'b0;
      wr = 1'b0;
      err = ERR_OK;
      if (int'(idx) >= NUM_LINES) begin
         r.message = MSG_NONE;
         r.message_dirty = 1'b0;
         r.write_data = 1'b0;
         r.error_code = ERR_ILLEGAL;
         r.new_state = ST_I;
         return r;
      end
      s = line_st[idx];
      ns = s;
      mark = line_mark[idx];
      lock = line_lock[idx];
      case (cmd)
         CMD_EVICT: begin
            case (s)
               ST_S: begin msg = MSG_PUTS; ns = ST_I; end
               ST_E: begin msg = MSG_PUTE; ns = ST_I; end
               ST_M: begin msg = MSG_PUTM; mdirty = 1'b1; ns = ST_I; end
               default: err = ERR_ILLEGAL;
            endcase
         end
         CMD_GETS: begin
            if (ll) mark = 1'b1;
            if (s == ST_I) begin ns = ST_IS; msg = MSG_FWD; end
         end
         CMD_GETX, CMD_GETSEX: begin
            if (s == ST_S) begin
               ns = ST_SM;
               msg = MSG_FWD;
            end else if (s == ST_I) begin
               ns = ST_IM;
               msg = MSG_FWD;
            end else begin
               if (s == ST_E) ns = ST_M;
               if (cmd == CMD_GETX) begin
                  if (first_level && locked) begin
                     if (lock == '0) err = ERR_ILLEGAL;
                     else lock = lock - 1'b1;
                  end
                  if (err == ERR_OK && first_level && (!sc || mark)) wr = 1'b1;
               end else if (first_level && lock != '1) begin
                  lock = lock + 1'b1;
               end
            end
         end
         CMD_PUTS: ;
         CMD_PUTM, CMD_PUTX, CMD_PUTXE: begin
            if (s != ST_M && s != ST_E) begin
               err = ERR_ILLEGAL;
            end else begin
               if ((s == ST_E && cmd != CMD_PUTXE) || dirty) ns = ST_M;
               if (cmd != CMD_PUTXE) wr = 1'b1;
            end
         end
         CMD_PUTE: begin
            if (s != ST_M && s != ST_E) err = ERR_ILLEGAL;
         end
         CMD_INV: begin
            if (s inside {ST_IS, ST_IM, ST_SM}) begin
               mark = 1'b0;
               if (ack && s == ST_SM) begin ns = ST_IM; msg = MSG_PUTS; end
            end else if (s == ST_S) begin
               mark = 1'b0;
               if (ack) msg = MSG_PUTS;
               ns = ST_I;
            end else begin
               err = ERR_ILLEGAL;
            end
         end
         CMD_FETCHINV, CMD_FETCHINVX: begin
            if (s != ST_M && s != ST_E) begin
               err = ERR_ILLEGAL;
            end else begin
               mark = 1'b0;
               msg = MSG_DATA;
               mdirty = (s == ST_M);
               ns = (cmd == CMD_FETCHINV) ? ST_I : ST_S;
            end
         end
         CMD_FILL: begin
            if (!data_rq) begin
               err = ERR_NODATA;
            end else begin
               if (s == ST_S || s == ST_IS) ns = gr_e ? ST_E : ST_S;
               else if (s inside {ST_M, ST_IM, ST_SM}) ns = ST_M;
               wr = 1'b1;
            end
         end
         CMD_FETCH_RESP: begin
            wr = 1'b1;
            if (dirty) ns = ST_M;
         end
         default: err = ERR_ILLEGAL;
      endcase
      if (err != ERR_OK) begin
         msg = MSG_NONE;
         mdirty = 1'b0;
         wr = 1'b0;
         ns = s;
      end else begin
         line_st[idx] = ns;
         line_mark[idx] = mark;
         line_lock[idx] = lock;
      end
      r.message = msg;
      r.message_dirty = mdirty;
      r.write_data = wr;
      r.error_code = err;
      r.new_state = ns;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            line_st[i] = ST_I;
            line_mark[i] = 1'b0;
            line_lock[i] = '0;
         end
         first_level = 1'b1;
         pending_rsp.delete();
         mismatches = 0;
      end else begin
         if (csr_write_enable) first_level = csr_write_data;
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: msg=%0d dirty=%0d wr=%0d err=%0d state=%0d",
                           rsp_message, rsp_message_dirty, rsp_write_data,
                           rsp_error_code, rsp_new_state);
            end else begin
               want = pending_rsp.pop_front();
               if (want.message !== rsp_message || want.message_dirty !== rsp_message_dirty ||
                   want.write_data !== rsp_write_data || want.error_code !== rsp_error_code ||
                   want.new_state !== rsp_new_state) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected msg=%0d dirty=%0d wr=%0d err=%0d state=%0d,",
                               " got msg=%0d dirty=%0d wr=%0d err=%0d state=%0d"},
                              want.message, want.message_dirty, want.write_data,
                              want.error_code, want.new_state, rsp_message,
                              rsp_message_dirty, rsp_write_data, rsp_error_code,
                              rsp_new_state);
               end
            end
         end
         if (req_push && !req_full)
            pending_rsp.push_back(apply_coherence_event(req_cmd, req_line_index,
               req_ack_needed, req_dirty_in, req_granted_exclusive, req_load_link,
               req_store_conditional, req_locked_access, req_orig_is_data_request));
      end
      outstanding = pending_rsp.size();
   end

endmodule

### tb/sv/mesi_line_state_controller_test.sv
module mesi_line_state_controller_test;
   import mlsc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 4'd15;
   localparam logic [6:0] F_ACK      = 7'b1000000;
   localparam logic [6:0] F_DIRTY    = 7'b0100000;
   localparam logic [6:0] F_GRANT_E  = 7'b0010000;
   localparam logic [6:0] F_LL       = 7'b0001000;
   localparam logic [6:0] F_SC       = 7'b0000100;
   localparam logic [6:0] F_LOCK_REL = 7'b0000010;
   localparam logic [6:0] F_DATA_RQ  = 7'b0000001;
   localparam logic [6:0] F_NONE     = 7'b0000000;
   localparam logic [INDEX_W-1:0] L_LO = '0;
   localparam logic [INDEX_W-1:0] L_HI = '1;
   localparam int WORDS_PER_PHASE = 260;
   localparam int NUM_PHASES = 5;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic               csr_write_data;
   logic               req_push;
   logic               req_full;
   logic [CMD_W-1:0]   req_cmd;
   logic [INDEX_W-1:0] req_line_index;
   logic               req_ack_needed;
   logic               req_dirty_in;
   logic               req_granted_exclusive;
   logic               req_load_link;
   logic               req_store_conditional;
   logic               req_locked_access;
   logic               req_orig_is_data_request;
   logic               rsp_pop;
   logic               rsp_empty;
   logic [2:0]         rsp_message;
   logic               rsp_message_dirty;
   logic               rsp_write_data;
   logic [1:0]         rsp_error_code;
   logic [2:0]         rsp_new_state;
   int                 mismatches;
   int                 outstanding;
   int                 words_sent;
   bit                 send_burst;

   mesi_line_state_controller uut (.*);

   mesi_line_state_controller_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("mesi_line_state_controller_test: done, errors");
      $finish;
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                            input logic [6:0] flags);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_cmd <= cmd;
      req_line_index <= idx;
      {req_ack_needed, req_dirty_in, req_granted_exclusive, req_load_link,
       req_store_conditional, req_locked_access, req_orig_is_data_request} <= flags;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_level(input logic level);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= level;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [INDEX_W-1:0] pick_line();
      if ($urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(0, 1023));
      return {{(INDEX_W-3){1'($urandom_range(0, 1))}}, 3'($urandom_range(0, 7))};
   endfunction

   function automatic logic [CMD_W-1:0] pick_request();
      case ($urandom_range(0, 2))
         0: return CMD_GETS;
         1: return CMD_GETX;
         default: return CMD_GETSEX;
      endcase
   endfunction

   task automatic run_random(input int upto);
      logic [INDEX_W-1:0] line;
      int kind;
      int k;
      while (words_sent < upto) begin
         line = pick_line();
         kind = $urandom_range(0, 9);
         if ($urandom_range(0, 199) == 0) drain_results();
         if (kind <= 4) begin
            send_word(CMD_W'($urandom_range(0, 15)), line, 7'($urandom_range(0, 127)));
         end else if (kind <= 7) begin
            send_word(pick_request(), line, 7'($urandom_range(0, 127)));
            if ($urandom_range(0, 3) == 0)
               send_word(CMD_INV, line, 7'($urandom_range(0, 127)));
            send_word(CMD_FILL, line, 7'($urandom_range(0, 127)) | F_DATA_RQ);
            repeat ($urandom_range(0, 3))
               send_word(pick_request(), line, 7'($urandom_range(0, 127)));
         end else begin
            k = $urandom_range(1, 18);
            repeat (k) send_word(CMD_GETSEX, line, 7'($urandom_range(0, 127)));
            repeat ($urandom_range(1, k + 2))
               send_word(CMD_GETX, line, 7'($urandom_range(0, 127)) | F_LOCK_REL);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_push = 1'b0;
      req_cmd = '0;
      req_line_index = '0;
      {req_ack_needed, req_dirty_in, req_granted_exclusive, req_load_link,
       req_store_conditional, req_locked_access, req_orig_is_data_request} = '0;
      words_sent = 0;
      send_burst = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_word(CMD_EVICT, L_LO, F_NONE);
      send_word(CMD_GETS, L_HI, F_LL);
      send_word(CMD_INV, L_HI, F_ACK);
      send_word(CMD_FILL, L_HI, F_GRANT_E);
      send_word(CMD_FILL, L_HI, F_DATA_RQ);
      send_word(CMD_GETX, L_HI, F_SC);
      send_word(CMD_INV, L_HI, F_ACK);
      send_word(CMD_GETSEX, L_HI, F_NONE);
      send_word(CMD_GETX, L_HI, F_SC);
      send_word(CMD_FILL, L_HI, F_DATA_RQ | F_GRANT_E);
      send_word(CMD_GETX, L_HI, F_LOCK_REL);
      send_word(CMD_GETX, L_HI, F_LOCK_REL);
      send_word(CMD_FETCHINVX, L_HI, F_NONE);
      send_word(CMD_INV, L_HI, F_NONE);
      send_word(CMD_INV, L_HI, F_ACK);
      send_word(CMD_PUTS, L_HI, F_NONE);
      send_word(CMD_PUTM, L_HI, F_DIRTY);
      send_word(CMD_FILL, L_LO, F_DATA_RQ);
      send_word(CMD_FETCH_RESP, L_LO, F_DIRTY);
      send_word(CMD_PUTXE, L_LO, F_NONE);
      send_word(CMD_EVICT, L_LO, F_NONE);
      send_word(CMD_GETS, L_LO, F_NONE);
      send_word(CMD_FILL, L_LO, F_DATA_RQ | F_GRANT_E);
      send_word(CMD_PUTE, L_LO, F_NONE);
      send_word(CMD_FETCHINV, L_LO, F_NONE);
      send_word(CMD_BAD, L_LO, F_NONE);
      send_word(CMD_UNUSED, L_HI, 7'h7F);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) write_level(p[0] ? 1'b0 : 1'b1);
         run_random((p + 1) * WORDS_PER_PHASE);
      end

      req_push <= 1'b0;
      wait (outstanding == 0);
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("mesi_line_state_controller_test: done, clean");
      else
         $display("mesi_line_state_controller_test: done, errors");
      $finish;
   end

   initial begin
      int gap;
      bit burst;
      rsp_pop = 1'b0;
      burst = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty !== 1'b0) @(posedge clock);
         @(negedge clock);
      end
   end

endmodule
